/* rtl/core/wipa_pkg.sv */
// Shared types, constants and register codes for the windowed-integral altitude PID.
`default_nettype none
package wipa_pkg;

	localparam int WINDOW_DEFAULT = 20;

	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 31;
	localparam int CFG_W   = 31;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 32;
	localparam int ERR_W   = 33;
	localparam int SUM_W   = 40;
	localparam int PROD_W  = SUM_W + GAIN_W + 1;
	localparam int ACC_W   = PROD_W + 2;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd1679;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd246;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd1147;
	localparam logic [GAIN_W-1:0]  STEP_TIME_RST = 16'd6554;
	localparam logic [LIMIT_W-1:0] SPEED_LIM_RST = 31'd65536;
	localparam logic [LIMIT_W-1:0] REACH_TOL_RST = 31'd6554;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_STEP_TIME = 3'd3,
		REG_SPEED_LIM = 3'd4,
		REG_REACH_TOL = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_DT,
		MUL_P,
		MUL_I,
		MUL_D
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM,
		ST_SUM,
		ST_MI,
		ST_MD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ring_upd;
		logic     acc_load;
		logic     acc_add;
		logic     finish;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/wipa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wipa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/wipa_ctrl.sv */
// Sequencer for one item: handshakes, multiplier schedule and output register valid.
`default_nettype none
module wipa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output wipa_pkg::cmd_t     cmd
);

	wipa_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wipa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.mul_sel  = wipa_pkg::MUL_DT;
		case (state_q)
			wipa_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = wipa_pkg::ST_TERM;
				end
			end
			wipa_pkg::ST_TERM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wipa_pkg::MUL_DT;
				state_d     = wipa_pkg::ST_SUM;
			end
			wipa_pkg::ST_SUM: begin
				cmd.ring_upd = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = wipa_pkg::MUL_P;
				state_d      = wipa_pkg::ST_MI;
			end
			wipa_pkg::ST_MI: begin
				cmd.acc_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = wipa_pkg::MUL_I;
				state_d      = wipa_pkg::ST_MD;
			end
			wipa_pkg::ST_MD: begin
				cmd.acc_add = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wipa_pkg::MUL_D;
				state_d     = wipa_pkg::ST_FIN;
			end
			wipa_pkg::ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = wipa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wipa_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/core/wipa_dp.sv */
// Datapath: config registers, term ring, window sum, shared multiplier and drive clamp.
`default_nettype none
module wipa_dp #(
	parameter int WINDOW = wipa_pkg::WINDOW_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [wipa_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [wipa_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [4*wipa_pkg::DATA_W-1:0]  in_data,
	input  wire wipa_pkg::cmd_t                 cmd,
	output logic      [wipa_pkg::DATA_W-1:0]    drive_value,
	output logic                                goal_reached
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int DW     = wipa_pkg::DATA_W;
	localparam int GW     = wipa_pkg::GAIN_W;
	localparam int LW     = wipa_pkg::LIMIT_W;
	localparam int EW     = wipa_pkg::ERR_W;
	localparam int SW     = wipa_pkg::SUM_W;
	localparam int PW     = wipa_pkg::PROD_W;
	localparam int AW     = wipa_pkg::ACC_W;
	localparam int TSH_W  = PW - 16;
	localparam int DRV_W  = AW - 12;

	// config
	logic [GW-1:0] gain_p_q, gain_i_q, gain_d_q, step_time_q;
	logic [LW-1:0] speed_limit_q, reach_tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= wipa_pkg::GAIN_P_RST;
			gain_i_q      <= wipa_pkg::GAIN_I_RST;
			gain_d_q      <= wipa_pkg::GAIN_D_RST;
			step_time_q   <= wipa_pkg::STEP_TIME_RST;
			speed_limit_q <= wipa_pkg::SPEED_LIM_RST;
			reach_tol_q   <= wipa_pkg::REACH_TOL_RST;
		end else if (cfg_we) begin
			case (wipa_pkg::reg_idx_t'(cfg_index))
				wipa_pkg::REG_GAIN_P:    gain_p_q      <= cfg_data[GW-1:0];
				wipa_pkg::REG_GAIN_I:    gain_i_q      <= cfg_data[GW-1:0];
				wipa_pkg::REG_GAIN_D:    gain_d_q      <= cfg_data[GW-1:0];
				wipa_pkg::REG_STEP_TIME: step_time_q   <= cfg_data[GW-1:0];
				wipa_pkg::REG_SPEED_LIM: speed_limit_q <= cfg_data[LW-1:0];
				wipa_pkg::REG_REACH_TOL: reach_tol_q   <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	// item capture
	logic signed [DW-1:0] setp, meas, rate, goal;
	logic signed [EW-1:0] goal_gap;
	logic        [EW-1:0] dist_abs;
	logic signed [EW-1:0] err_q;
	logic signed [DW-1:0] rate_q;
	logic                 reached_q;

	assign setp = in_data[DW-1:0];
	assign meas = in_data[2*DW-1:DW];
	assign rate = in_data[3*DW-1:2*DW];
	assign goal = in_data[4*DW-1:3*DW];

	assign goal_gap = EW'(setp) - EW'(goal);
	assign dist_abs = goal_gap[EW-1] ? EW'(-goal_gap) : EW'(goal_gap);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q     <= EW'(setp) - EW'(meas);
			rate_q    <= rate;
			reached_q <= (dist_abs <= {{(EW-LW){1'b0}}, reach_tol_q});
		end
	end

	// shared multiplier
	logic signed [SW-1:0]   mul_a;
	logic signed [GW:0]     mul_b;
	logic signed [PW-1:0]   prod_q;
	logic signed [SW-1:0]   sum_q;

	always_comb begin
		case (cmd.mul_sel)
			wipa_pkg::MUL_DT: begin
				mul_a = SW'(err_q);
				mul_b = {1'b0, step_time_q};
			end
			wipa_pkg::MUL_P: begin
				mul_a = SW'(err_q);
				mul_b = {1'b0, gain_p_q};
			end
			wipa_pkg::MUL_I: begin
				mul_a = sum_q;
				mul_b = {1'b0, gain_i_q};
			end
			wipa_pkg::MUL_D: begin
				mul_a = SW'(rate_q);
				mul_b = {1'b0, gain_d_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// term ring
	logic [PTR_W-1:0]      ptr_q;
	logic [WINDOW-1:0]     valid_q;
	logic [DW-1:0]         ring_rdata;
	logic signed [DW-1:0]  old_term;
	logic signed [TSH_W-1:0] term_sh;
	logic signed [DW-1:0]  term;
	logic                  term_fits;

	assign term_sh   = prod_q[PW-1:16];
	assign term_fits = (term_sh[TSH_W-1:DW-1] == '0) || (term_sh[TSH_W-1:DW-1] == '1);
	always_comb begin
		if (term_fits) begin
			term = term_sh[DW-1:0];
		end else if (term_sh[TSH_W-1]) begin
			term = {1'b1, {(DW-1){1'b0}}};
		end else begin
			term = {1'b0, {(DW-1){1'b1}}};
		end
	end

	assign old_term = valid_q[ptr_q] ? ring_rdata : '0;

	wipa_ram #(
		.WIDTH (DW),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_upd),
		.waddr (ptr_q),
		.wdata (term),
		.raddr (ptr_q),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			valid_q <= '0;
			sum_q   <= '0;
		end else if (cmd.finish && reached_q) begin
			ptr_q   <= '0;
			valid_q <= '0;
			sum_q   <= '0;
		end else if (cmd.ring_upd) begin
			valid_q[ptr_q] <= 1'b1;
			sum_q          <= sum_q + SW'(term) - SW'(old_term);
			if (ptr_q == PTR_W'(WINDOW - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// accumulate and clamp
	logic signed [AW-1:0]    acc_q;
	logic signed [AW-1:0]    acc_fin;
	logic signed [DRV_W-1:0] drv_full;
	logic signed [DRV_W-1:0] lim;
	logic        [DW-1:0]    drive_q;
	logic                    reached_out_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			acc_q <= AW'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + AW'(prod_q);
		end
	end

	assign acc_fin  = acc_q + AW'(prod_q);
	assign drv_full = acc_fin[AW-1:12];
	assign lim      = {{(DRV_W-LW){1'b0}}, speed_limit_q};

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			reached_out_q <= reached_q;
			if (drv_full > lim) begin
				drive_q <= lim[DW-1:0];
			end else if (drv_full < -lim) begin
				drive_q <= DW'(-lim);
			end else begin
				drive_q <= drv_full[DW-1:0];
			end
		end
	end

	assign drive_value  = drive_q;
	assign goal_reached = reached_out_q;

endmodule
`default_nettype wire

/* rtl/core/windowed_integral_pid_altitude.sv */
// An item steps through term, sum, I, D and finish states before m_tvalid rises.
// A new item is taken only once the last one has finished; the work is bound by the
// single shared 17x40 multiplier, used in turn for step time and the three gains.
// A result waiting on m_tready holds the block in its last step only.
// Reset: config registers take their defaults; the integral ring is emptied at
// once through per-entry valid bits, so no clearing pass follows reset.
`default_nettype none
module windowed_integral_pid_altitude #(
	parameter int WINDOW = wipa_pkg::WINDOW_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [wipa_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [wipa_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// setpoint_altitude, measured_altitude, measured_climb_rate, goal_altitude
	input  wire logic [4*wipa_pkg::DATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// drive_value
	output logic      [wipa_pkg::DATA_W-1:0]        m_tdata,
	// goal_reached
	output logic                                    m_tuser
);

	wipa_pkg::cmd_t cmd;

	wipa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	wipa_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_data      (s_tdata),
		.cmd          (cmd),
		.drive_value  (m_tdata),
		.goal_reached (m_tuser)
	);

endmodule
`default_nettype wire

/* rtl/core/wipa_chk.sv */
// Port-level checker for the windowed-integral altitude PID, bound to the top level.
`default_nettype none
module wipa_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [wipa_pkg::DATA_W-1:0]   m_tdata,
	input wire logic                          m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input taken while an item is still in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result item appeared without work in progress");

	a_no_result_right_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result item appeared one cycle after accept");

endmodule

bind windowed_integral_pid_altitude wipa_chk u_wipa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* test/windowed_integral_pid_altitude_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the windowed-integral altitude PID, directed and random items.
module windowed_integral_pid_altitude_tb;

	localparam int RING_DEPTH  = wipa_pkg::WINDOW_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_LEN    = 500;
	localparam logic [wipa_pkg::IDX_W-1:0] IDX_SPARE_A = 3'd6;
	localparam logic [wipa_pkg::IDX_W-1:0] IDX_SPARE_B = 3'd7;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [wipa_pkg::DATA_W-1:0] goal;
		logic signed [wipa_pkg::DATA_W-1:0] rate;
		logic signed [wipa_pkg::DATA_W-1:0] meas;
		logic signed [wipa_pkg::DATA_W-1:0] setp;
	} sample_t;

	typedef struct packed {
		logic [wipa_pkg::DATA_W-1:0] drive;
		logic                        reached;
	} drive_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [wipa_pkg::IDX_W-1:0]        cfg_index = '0;
	logic [wipa_pkg::CFG_W-1:0]        cfg_data = '0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [4*wipa_pkg::DATA_W-1:0]     s_tdata = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [wipa_pkg::DATA_W-1:0]       m_tdata;
	logic                              m_tuser;

	sample_t pending[$];
	drive_t  drive_q[$];

	longint gp_r = wipa_pkg::GAIN_P_RST;
	longint gi_r = wipa_pkg::GAIN_I_RST;
	longint gd_r = wipa_pkg::GAIN_D_RST;
	longint dt_r = wipa_pkg::STEP_TIME_RST;
	longint lim_r = wipa_pkg::SPEED_LIM_RST;
	longint tol_r = wipa_pkg::REACH_TOL_RST;
	longint ring[RING_DEPTH] = '{default: 0};
	longint win_sum = 0;
	int     ring_ptr = 0;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int mismatches = 0;
	int cycle_count = 0;

	windowed_integral_pid_altitude uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic void predict_drive(sample_t s);
		longint setp, meas, rate, goal, err, term, acc, drv, goal_gap;
		drive_t res;
		setp = longint'(s.setp);
		meas = longint'(s.meas);
		rate = longint'(s.rate);
		goal = longint'(s.goal);
		err = setp - meas;
		term = (err * dt_r) >>> 16;
		if (term > S32_MAX) term = S32_MAX;
		if (term < S32_MIN) term = S32_MIN;
		win_sum = win_sum + term - ring[ring_ptr];
		ring[ring_ptr] = term;
		ring_ptr = (ring_ptr + 1) % RING_DEPTH;
		acc = gp_r * err + gi_r * win_sum + gd_r * rate;
		drv = acc >>> 12;
		if (drv > lim_r) drv = lim_r;
		if (drv < -lim_r) drv = -lim_r;
		goal_gap = setp - goal;
		if (goal_gap < 0) goal_gap = -goal_gap;
		res.drive = drv[wipa_pkg::DATA_W-1:0];
		res.reached = (goal_gap <= tol_r);
		if (res.reached) begin
			ring = '{default: 0};
			win_sum = 0;
			ring_ptr = 0;
		end
		drive_q.push_back(res);
	endfunction

	task automatic add_sample(longint setp, longint meas, longint rate, longint goal);
		sample_t s;
		s.setp = setp[wipa_pkg::DATA_W-1:0];
		s.meas = meas[wipa_pkg::DATA_W-1:0];
		s.rate = rate[wipa_pkg::DATA_W-1:0];
		s.goal = goal[wipa_pkg::DATA_W-1:0];
		pending.push_back(s);
	endtask

	// approach toward a goal from above or below, usually ending inside the reach window
	task automatic add_approach();
		longint goal, span, setp, t, rate;
		int len;
		bit land;
		t = (tol_r > 64'd16777216) ? 64'd16777216 : tol_r;
		len = $urandom_range(45, 3);
		goal = longint'($urandom_range(1048576)) - 524288;
		span = t + $urandom_range(1048576, 1);
		if ($urandom_range(1)) span = -span;
		land = ($urandom_range(9) != 0);
		for (int k = 0; k < len; k++) begin
			setp = goal + span * (len - k) / len;
			rate = ($urandom_range(19) == 0) ? longint'($signed(32'($urandom)))
				: longint'($urandom_range(524288)) - 262144;
			add_sample(setp, setp + longint'($urandom_range(262144)) - 131072, rate, goal);
		end
		if (land) begin
			setp = goal + longint'($urandom_range(32'(2 * t))) - t;
			add_sample(setp, setp + longint'($urandom_range(4096)) - 2048, 0, goal);
		end
	endtask

	task automatic write_reg(logic [wipa_pkg::IDX_W-1:0] idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[wipa_pkg::CFG_W-1:0];
		case (idx)
			wipa_pkg::REG_GAIN_P:    gp_r = val & 64'hFFFF;
			wipa_pkg::REG_GAIN_I:    gi_r = val & 64'hFFFF;
			wipa_pkg::REG_GAIN_D:    gd_r = val & 64'hFFFF;
			wipa_pkg::REG_STEP_TIME: dt_r = val & 64'hFFFF;
			wipa_pkg::REG_SPEED_LIM: lim_r = val & 64'h7FFFFFFF;
			wipa_pkg::REG_REACH_TOL: tol_r = val & 64'h7FFFFFFF;
			default: ;
		endcase
	endtask

	task automatic apply_settings(longint gp, longint gi, longint gd, longint dt,
		longint lim, longint tol);
		write_reg(IDX_SPARE_A, $urandom);
		write_reg(wipa_pkg::REG_GAIN_P, gp);
		write_reg(wipa_pkg::REG_GAIN_I, gi);
		write_reg(wipa_pkg::REG_GAIN_D, gd);
		write_reg(wipa_pkg::REG_STEP_TIME, dt);
		write_reg(wipa_pkg::REG_SPEED_LIM, lim);
		write_reg(wipa_pkg::REG_REACH_TOL, tol);
		write_reg(IDX_SPARE_B, $urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending.size() != 0 || s_tvalid || drive_q.size() != 0);
	endtask

	task automatic run_phase(int snd, int rcv, int n);
		snd_idle_pct <= snd;
		rcv_stall_pct <= rcv;
		while (pending.size() < n) begin
			if ($urandom_range(99) < 15)
				add_sample($signed(32'($urandom)), $signed(32'($urandom)),
					$signed(32'($urandom)), $signed(32'($urandom)));
			else
				add_approach();
		end
		wait_drained();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				s_tdata <= pending.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// random ready, with one long hold-off to back the pipe up into the input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		drive_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (drive_q.size() == 0) begin
					$error("unexpected item: drive_value %0d goal_reached %0d",
						$signed(m_tdata), m_tuser);
					mismatches++;
				end else begin
					want = drive_q.pop_front();
					if (m_tdata !== want.drive) begin
						$error("drive_value: expected %0d, actual %0d",
							$signed(want.drive), $signed(m_tdata));
						mismatches++;
					end
					if (m_tuser !== want.reached) begin
						$error("goal_reached: expected %0d, actual %0d", want.reached, m_tuser);
						mismatches++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (s_tvalid && s_tready)
				predict_drive(sample_t'(s_tdata));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		add_sample(0, 0, 0, 0);
		add_sample(S32_MAX, S32_MIN, S32_MAX, S32_MIN);
		add_sample(S32_MIN, S32_MAX, S32_MIN, S32_MAX);
		add_sample(1000, 900, 0, 1000 + 6554);
		add_sample(1000, 900, 0, 1000 + 6555);
		add_sample(-5000, -4000, 0, -5000 - 6554);
		add_sample(-5000, -4000, 0, -5000 - 6555);
		add_sample(0, 0, S32_MAX, S32_MIN);
		add_sample(0, 0, S32_MIN, S32_MIN);
		// constant error; with the three items before it this wraps the ring
		for (int k = 0; k < 18; k++)
			add_sample(200000, 0, 0, -1000000);
		wait_drained();

		apply_settings($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(4194304), $urandom_range(1048576));
		run_phase(0, 0, 350);

		apply_settings(64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF,
			64'h7FFFFFFF, 64'h7FFFFFFF);
		run_phase(69, 0, 300);

		apply_settings(0, 0, 0, 0, 0, 0);
		run_phase(0, 69, 200);

		apply_settings($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
			$urandom_range(65535), $urandom, $urandom_range(262144));
		run_phase(24, 24, 300);

		apply_settings(wipa_pkg::GAIN_P_RST, wipa_pkg::GAIN_I_RST, wipa_pkg::GAIN_D_RST,
			wipa_pkg::STEP_TIME_RST, wipa_pkg::SPEED_LIM_RST, wipa_pkg::REACH_TOL_RST);
		run_phase(0, 0, 300);

		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
